@@ rtl/fte_pkg.sv @@
// ----------------------------------------------------------------------------
// fte_pkg - shared types and constants of the junction temperature estimator
// Control words between the top level, the RC lanes and the merge stage, plus
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package fte_pkg;

   // Width of the registered gain term: floor(g * loss * 2^shift / 2^16)
   localparam int GAIN_TERM_W = 48;

   // Configuration port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   // Register indexes (byte address is 8 * index)
   localparam logic [REG_IDX_W-1:0] REG_IGBT_DECAY    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IGBT_GAIN     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DIODE_DECAY   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DIODE_GAIN    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COEFF = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PAD_COEFF     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_SHIFT    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SOLVER_MODE   = 3'd7;

   // Solver modes
   localparam logic MODE_EULER = 1'b0;
   localparam logic MODE_HOLD  = 1'b1;

   // Lane control: load the gain term, step the rise, hold, gain exponent
   typedef struct packed {
      logic       load;
      logic       step;
      logic       hold;
      logic [3:0] gain_shift;
   } lane_ctl_type;

   // Merge control: load partial sums, load the result word
   typedef struct packed {
      logic load_part;
      logic load_out;
   } merge_ctl_type;

endpackage

@@ rtl/fte_lane.sv @@
// ----------------------------------------------------------------------------
// fte_lane - one Foster RC stage
// Registers the gain term of an accepted word, then advances the stage rise
// by one forward-Euler step: rise = sat(floor(d*rise/2^16) + gain term).
// ----------------------------------------------------------------------------
module fte_lane
   import fte_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lane_ctl_type                 ctl,
   input  logic [15:0]                  decay,
   input  logic [15:0]                  gain,
   input  logic signed [31:0]           loss,
   output logic signed [DATA_WIDTH-1:0] rise
);

   localparam int PROD_W = DATA_WIDTH + 17;
   localparam int SUM_W  = (DATA_WIDTH + 2 > GAIN_TERM_W + 1) ? DATA_WIDTH + 2
                                                              : GAIN_TERM_W + 1;
   localparam logic signed [DATA_WIDTH-1:0] RISE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] RISE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [48:0]              gain_prod;
   logic signed [63:0]              gain_scaled;
   logic signed [GAIN_TERM_W-1:0]   gain_term_in;
   logic signed [GAIN_TERM_W-1:0]   gain_term_ff;
   logic signed [PROD_W-1:0]        decay_prod;
   logic signed [DATA_WIDTH:0]      decay_term;
   logic signed [SUM_W-1:0]         step_sum;
   logic signed [DATA_WIDTH-1:0]    rise_in;
   logic signed [DATA_WIDTH-1:0]    rise_ff;

   // Gain term: scale by 2^shift, floor by 2^16
   always_comb begin
      gain_prod    = $signed({1'b0, gain}) * loss;
      gain_scaled  = 64'(gain_prod) <<< ctl.gain_shift;
      gain_term_in = $signed(gain_scaled[63:16]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         gain_term_ff <= gain_term_in;
      end
   end

   // Decay term, sum and saturate to the rise range
   always_comb begin
      decay_prod = $signed({1'b0, decay}) * rise_ff;
      decay_term = $signed(decay_prod[PROD_W-1:16]);
      step_sum   = SUM_W'(decay_term) + SUM_W'(gain_term_ff);
      if (step_sum > SUM_W'(RISE_MAX)) begin
         rise_in = RISE_MAX;
      end else if (step_sum < SUM_W'(RISE_MIN)) begin
         rise_in = RISE_MIN;
      end else begin
         rise_in = step_sum[DATA_WIDTH-1:0];
      end
   end

   // Advance the stage unless held
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= '0;
      end else if (ctl.step && !ctl.hold) begin
         rise_ff <= rise_in;
      end
   end

   assign rise = rise_ff;

endmodule

@@ rtl/fte_merge.sv @@
// ----------------------------------------------------------------------------
// fte_merge - junction temperature of one network
// Adds ambient and six stage rises over two registered steps and saturates
// the total to the signed 32-bit range.
// ----------------------------------------------------------------------------
module fte_merge
   import fte_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  merge_ctl_type             ctl,
   input  logic [6*DATA_WIDTH-1:0]   rises,     // six rises, first in low bits
   input  logic signed [31:0]        ambient,
   output logic [31:0]               junction_temp
);

   localparam int ACC_W = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 3;
   localparam logic signed [31:0] TEMP_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] TEMP_MIN = 32'sh8000_0000;

   logic signed [DATA_WIDTH-1:0] r0, r1, r2, r3, r4, r5;
   logic signed [ACC_W-1:0]      part_a_in, part_b_in;
   logic signed [ACC_W-1:0]      part_a_ff, part_b_ff;
   logic signed [ACC_W-1:0]      total;
   logic [31:0]                  temp_in;
   logic [31:0]                  temp_ff;

   always_comb begin
      r0 = $signed(rises[0*DATA_WIDTH +: DATA_WIDTH]);
      r1 = $signed(rises[1*DATA_WIDTH +: DATA_WIDTH]);
      r2 = $signed(rises[2*DATA_WIDTH +: DATA_WIDTH]);
      r3 = $signed(rises[3*DATA_WIDTH +: DATA_WIDTH]);
      r4 = $signed(rises[4*DATA_WIDTH +: DATA_WIDTH]);
      r5 = $signed(rises[5*DATA_WIDTH +: DATA_WIDTH]);
      part_a_in = ACC_W'(ambient) + ACC_W'(r0) + ACC_W'(r1) + ACC_W'(r2);
      part_b_in = ACC_W'(r3) + ACC_W'(r4) + ACC_W'(r5);
   end

   // Partial sums
   always_ff @(posedge clock) begin
      if (ctl.load_part) begin
         part_a_ff <= part_a_in;
         part_b_ff <= part_b_in;
      end
   end

   // Final add and saturate
   always_comb begin
      total = part_a_ff + part_b_ff;
      if (total > ACC_W'(TEMP_MAX)) begin
         temp_in = TEMP_MAX;
      end else if (total < ACC_W'(TEMP_MIN)) begin
         temp_in = TEMP_MIN;
      end else begin
         temp_in = total[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         temp_ff <= temp_in;
      end
   end

   assign junction_temp = temp_ff;

endmodule

@@ rtl/foster_thermal_junction_estimator.sv @@
// ----------------------------------------------------------------------------
// foster_thermal_junction_estimator - IGBT and diode junction temperatures
// Two Foster RC networks, six stages each, advanced by forward Euler per
// sample; twelve RC lanes run side by side and two merge units sum them.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one word per loss sample (IGBT loss, diode loss, ambient).
//   rsp_* : one word per sample (IGBT and diode junction temperature).
//   csr_* : 64-bit register port, register i at byte address 8*i.
// Throughput: one word per cycle while rsp_tready is high. The limit is the
//   state loop inside each RC lane: one 17 x DATA_WIDTH multiply, an add
//   and a saturate per cycle.
// The pipeline has four stages (gain term, state step, partial sums, result);
//   each stage moves on as soon as the one after it is empty or moving, so a
//   new word is taken while a finished result waits on rsp_tready.
// When the receiver stalls, words fill the free stages and then req_tready
//   drops; the RC state only advances when a word leaves the first stage.
// Reset clears all registers to zero, all stage rises to zero and empties the
//   pipeline. Registers must be written only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
module foster_thermal_junction_estimator
   import fte_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,   // power_loss_igbt, power_loss_diode,
                                              // ambient_temp
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // igbt_junction_temp,
                                              // diode_junction_temp
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [63:0]          igbt_decay_pack_ff;
   logic [63:0]          igbt_gain_pack_ff;
   logic [63:0]          diode_decay_pack_ff;
   logic [63:0]          diode_gain_pack_ff;
   logic [63:0]          channel_coeff_pack_ff;
   logic [31:0]          pad_coeff_pack_ff;
   logic [3:0]           gain_shift_ff;
   logic                 solver_mode_ff;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         igbt_decay_pack_ff    <= '0;
         igbt_gain_pack_ff     <= '0;
         diode_decay_pack_ff   <= '0;
         diode_gain_pack_ff    <= '0;
         channel_coeff_pack_ff <= '0;
         pad_coeff_pack_ff     <= '0;
         gain_shift_ff         <= '0;
         solver_mode_ff        <= MODE_EULER;
      end else if (csr_write) begin
         case (csr_index)
            REG_IGBT_DECAY:    igbt_decay_pack_ff    <= csr_pwdata;
            REG_IGBT_GAIN:     igbt_gain_pack_ff     <= csr_pwdata;
            REG_DIODE_DECAY:   diode_decay_pack_ff   <= csr_pwdata;
            REG_DIODE_GAIN:    diode_gain_pack_ff    <= csr_pwdata;
            REG_CHANNEL_COEFF: channel_coeff_pack_ff <= csr_pwdata;
            REG_PAD_COEFF:     pad_coeff_pack_ff     <= csr_pwdata[31:0];
            REG_GAIN_SHIFT:    gain_shift_ff         <= csr_pwdata[3:0];
            REG_SOLVER_MODE:   solver_mode_ff        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_index)
         REG_IGBT_DECAY:    csr_prdata = igbt_decay_pack_ff;
         REG_IGBT_GAIN:     csr_prdata = igbt_gain_pack_ff;
         REG_DIODE_DECAY:   csr_prdata = diode_decay_pack_ff;
         REG_DIODE_GAIN:    csr_prdata = diode_gain_pack_ff;
         REG_CHANNEL_COEFF: csr_prdata = channel_coeff_pack_ff;
         REG_PAD_COEFF:     csr_prdata = {32'd0, pad_coeff_pack_ff};
         REG_GAIN_SHIFT:    csr_prdata = {60'd0, gain_shift_ff};
         REG_SOLVER_MODE:   csr_prdata = {63'd0, solver_mode_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_ready;
   logic load1, adv1, adv2, adv3;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s3_ready  = !s3_valid_ff  || out_ready;
   assign s2_ready  = !s2_valid_ff  || s3_ready;
   assign s1_ready  = !s1_valid_ff  || s2_ready;

   assign req_tready = s1_ready;
   assign rsp_tvalid = out_valid_ff;

   assign load1 = req_tvalid  && s1_ready;
   assign adv1  = s1_valid_ff && s2_ready;
   assign adv2  = s2_valid_ff && s3_ready;
   assign adv3  = s3_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_tvalid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) out_valid_ff <= s3_valid_ff;
      end
   end

   // Carry ambient along to the merge stage
   logic signed [31:0] s1_ambient_ff, s2_ambient_ff;

   always_ff @(posedge clock) begin
      if (load1) s1_ambient_ff <= $signed(req_tdata[95:64]);
      if (adv1)  s2_ambient_ff <= s1_ambient_ff;
   end

   // ------------------------------------------------------------------------
   // Loss inputs
   // ------------------------------------------------------------------------
   logic signed [31:0] loss_igbt, loss_diode, loss_pad;
   logic signed [32:0] loss_sum;

   always_comb begin
      loss_igbt  = $signed(req_tdata[31:0]);
      loss_diode = $signed(req_tdata[63:32]);
      loss_sum   = 33'(loss_igbt) + 33'(loss_diode);
      if (loss_sum > 33'sh0_7FFF_FFFF) begin
         loss_pad = 32'sh7FFF_FFFF;
      end else if (loss_sum < -33'sh0_8000_0000) begin
         loss_pad = 32'sh8000_0000;
      end else begin
         loss_pad = loss_sum[31:0];
      end
   end

   // ------------------------------------------------------------------------
   // RC lanes: IGBT 0..4, diode 5..9, pads 10 and 11
   // ------------------------------------------------------------------------
   lane_ctl_type lane_ctl;
   logic [12*DATA_WIDTH-1:0] rise_all;

   assign lane_ctl = '{load: load1, step: adv1, hold: (solver_mode_ff == MODE_HOLD),
                       gain_shift: gain_shift_ff};

   for (genvar k = 0; k < 4; k++) begin : g_stage
      fte_lane #(.DATA_WIDTH(DATA_WIDTH)) u_igbt (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .decay (igbt_decay_pack_ff[16*k +: 16]),
         .gain  (igbt_gain_pack_ff[16*k +: 16]),
         .loss  (loss_igbt),
         .rise  (rise_all[k*DATA_WIDTH +: DATA_WIDTH])
      );
      fte_lane #(.DATA_WIDTH(DATA_WIDTH)) u_diode (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .decay (diode_decay_pack_ff[16*k +: 16]),
         .gain  (diode_gain_pack_ff[16*k +: 16]),
         .loss  (loss_diode),
         .rise  (rise_all[(k+5)*DATA_WIDTH +: DATA_WIDTH])
      );
   end

   fte_lane #(.DATA_WIDTH(DATA_WIDTH)) u_igbt_channel (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .decay (channel_coeff_pack_ff[15:0]),
      .gain  (channel_coeff_pack_ff[31:16]),
      .loss  (loss_igbt),
      .rise  (rise_all[4*DATA_WIDTH +: DATA_WIDTH])
   );

   fte_lane #(.DATA_WIDTH(DATA_WIDTH)) u_diode_channel (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .decay (channel_coeff_pack_ff[47:32]),
      .gain  (channel_coeff_pack_ff[63:48]),
      .loss  (loss_diode),
      .rise  (rise_all[9*DATA_WIDTH +: DATA_WIDTH])
   );

   fte_lane #(.DATA_WIDTH(DATA_WIDTH)) u_igbt_pad (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .decay (pad_coeff_pack_ff[15:0]),
      .gain  (pad_coeff_pack_ff[31:16]),
      .loss  (loss_pad),
      .rise  (rise_all[10*DATA_WIDTH +: DATA_WIDTH])
   );

   fte_lane #(.DATA_WIDTH(DATA_WIDTH)) u_diode_pad (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .decay (pad_coeff_pack_ff[15:0]),
      .gain  (pad_coeff_pack_ff[31:16]),
      .loss  (loss_pad),
      .rise  (rise_all[11*DATA_WIDTH +: DATA_WIDTH])
   );

   // ------------------------------------------------------------------------
   // Merge: ambient plus six rises per network
   // ------------------------------------------------------------------------
   merge_ctl_type merge_ctl;

   assign merge_ctl = '{load_part: adv2, load_out: adv3};

   fte_merge #(.DATA_WIDTH(DATA_WIDTH)) u_merge_igbt (
      .clock         (clock),
      .ctl           (merge_ctl),
      .rises         ({rise_all[11*DATA_WIDTH-1:10*DATA_WIDTH],
                       rise_all[5*DATA_WIDTH-1:0]}),
      .ambient       (s2_ambient_ff),
      .junction_temp (rsp_tdata[31:0])
   );

   fte_merge #(.DATA_WIDTH(DATA_WIDTH)) u_merge_diode (
      .clock         (clock),
      .ctl           (merge_ctl),
      .rises         ({rise_all[12*DATA_WIDTH-1:11*DATA_WIDTH],
                       rise_all[10*DATA_WIDTH-1:5*DATA_WIDTH]}),
      .ambient       (s2_ambient_ff),
      .junction_temp (rsp_tdata[63:32])
   );

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
   // RC state moves only on a Euler step of a word leaving the first stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv1 || solver_mode_ff == MODE_HOLD) |=> $stable(rise_all))
      else $error("RC state changed without a step");

   // A taken word occupies the first stage
   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      load1 |=> s1_valid_ff)
      else $error("first stage empty after accept");

   // A stepped word occupies the second stage
   a_s2_fill: assert property (@(posedge clock) disable iff (reset)
      adv1 |=> s2_valid_ff)
      else $error("second stage empty after state step");

   // A result leaving the partial-sum stage shows up on the output
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      adv3 |=> out_valid_ff)
      else $error("result lost between merge stages");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - junction temperature estimator
// Streams loss sample words through the block under zero, typical, full-scale
// and random coefficient sets and in both solver modes. A tracker steps both
// Foster networks alongside the block and checks every result word.
// ----------------------------------------------------------------------------
module testbench;
   import fte_pkg::*;

   localparam int RISE_W      = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 6;
   localparam int PHASE_WORDS = 66;
   localparam int NUM_PHASES  = 6;

   localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef enum {COEFF_ZERO, COEFF_TYPICAL, COEFF_FULL, COEFF_RANDOM} coeff_set_type;

   // Result word layout, lowest field last
   typedef struct packed {
      logic [31:0] diode_tj;
      logic [31:0] igbt_tj;
   } junction_pair_type;

   // Tracks register contents and stage rises, queues the due temperatures
   class junction_temp_board;
      logic [63:0]       igbt_decay;
      logic [63:0]       igbt_gain;
      logic [63:0]       diode_decay;
      logic [63:0]       diode_gain;
      logic [63:0]       channel_coeff;
      logic [31:0]       pad_coeff;
      logic [3:0]        gain_shift;
      logic              solver_mode;
      longint            igbt_rise[5];
      longint            diode_rise[5];
      longint            pad_rise[2];
      junction_pair_type temps_due[$];
      int                errors;

      function new();
         igbt_decay    = '0;
         igbt_gain     = '0;
         diode_decay   = '0;
         diode_gain    = '0;
         channel_coeff = '0;
         pad_coeff     = '0;
         gain_shift    = '0;
         solver_mode   = MODE_EULER;
         foreach (igbt_rise[k]) igbt_rise[k] = 0;
         foreach (diode_rise[k]) diode_rise[k] = 0;
         foreach (pad_rise[k]) pad_rise[k] = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
         case (idx)
            REG_IGBT_DECAY:    igbt_decay    = value;
            REG_IGBT_GAIN:     igbt_gain     = value;
            REG_DIODE_DECAY:   diode_decay   = value;
            REG_DIODE_GAIN:    diode_gain    = value;
            REG_CHANNEL_COEFF: channel_coeff = value;
            REG_PAD_COEFF:     pad_coeff     = value[31:0];
            REG_GAIN_SHIFT:    gain_shift    = value[3:0];
            REG_SOLVER_MODE:   solver_mode   = value[0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint x, int bits);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (x > hi) return hi;
         if (x < lo) return lo;
         return x;
      endfunction

      // One forward-Euler step; arithmetic right shift floors both terms
      function longint rc_step(longint rise, logic [15:0] d, logic [15:0] g, longint drive);
         longint dl;
         longint gl;
         longint decay_term;
         longint gain_term;
         dl = d;
         gl = g;
         decay_term = (dl * rise) >>> 16;
         gain_term  = ((gl * drive) <<< gain_shift) >>> 16;
         return clamp(decay_term + gain_term, RISE_W);
      endfunction

      function void take_sample(logic [95:0] word);
         logic signed [31:0] f_igbt;
         logic signed [31:0] f_diode;
         logic signed [31:0] f_amb;
         longint             p_igbt;
         longint             p_diode;
         longint             p_sum;
         longint             tj_igbt;
         longint             tj_diode;
         junction_pair_type  due;
         int                 k;
         f_igbt  = word[31:0];
         f_diode = word[63:32];
         f_amb   = word[95:64];
         p_igbt  = f_igbt;
         p_diode = f_diode;
         // Advance all twelve stages unless the solver holds
         if (solver_mode == MODE_EULER) begin
            p_sum = clamp(p_igbt + p_diode, 32);
            for (k = 0; k < 4; k++) begin
               igbt_rise[k]  = rc_step(igbt_rise[k], igbt_decay[16*k +: 16],
                                       igbt_gain[16*k +: 16], p_igbt);
               diode_rise[k] = rc_step(diode_rise[k], diode_decay[16*k +: 16],
                                       diode_gain[16*k +: 16], p_diode);
            end
            igbt_rise[4]  = rc_step(igbt_rise[4], channel_coeff[15:0],
                                    channel_coeff[31:16], p_igbt);
            diode_rise[4] = rc_step(diode_rise[4], channel_coeff[47:32],
                                    channel_coeff[63:48], p_diode);
            pad_rise[0]   = rc_step(pad_rise[0], pad_coeff[15:0], pad_coeff[31:16], p_sum);
            pad_rise[1]   = rc_step(pad_rise[1], pad_coeff[15:0], pad_coeff[31:16], p_sum);
         end
         // Sum ambient and the six rises of each network
         tj_igbt  = longint'(f_amb) + pad_rise[0];
         tj_diode = longint'(f_amb) + pad_rise[1];
         for (k = 0; k < 5; k++) begin
            tj_igbt  += igbt_rise[k];
            tj_diode += diode_rise[k];
         end
         due.igbt_tj  = 32'(clamp(tj_igbt, 32));
         due.diode_tj = 32'(clamp(tj_diode, 32));
         temps_due.push_back(due);
      endfunction

      function void check_temps(logic [63:0] word);
         junction_pair_type got;
         junction_pair_type due;
         got = word;
         if (temps_due.size() == 0) begin
            $error("result word 0x%h arrived with no sample outstanding", word);
            errors++;
         end else begin
            due = temps_due.pop_front();
            if (got.igbt_tj !== due.igbt_tj) begin
               $error("igbt_junction_temp: expected 0x%h, actual 0x%h",
                      due.igbt_tj, got.igbt_tj);
               errors++;
            end
            if (got.diode_tj !== due.diode_tj) begin
               $error("diode_junction_temp: expected 0x%h, actual 0x%h",
                      due.diode_tj, got.diode_tj);
               errors++;
            end
         end
      endfunction

      function int pending();
         return temps_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [95:0]           req_tdata;   // power_loss_igbt, power_loss_diode, ambient_temp
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [63:0]           rsp_tdata;   // igbt_junction_temp, diode_junction_temp
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   junction_temp_board board;
   bit                 steady;
   int                 cycle_count;

   foster_thermal_junction_estimator #(
      .DATA_WIDTH (RISE_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Give up on a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Stall the result side at random, never during the steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 17);
   end

   // Note accepted samples and check accepted result words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.take_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_temps(rsp_tdata);
      end
   end

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop valid and hold until every due result word has come back
   task automatic wait_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] decay16();
      return 16'($urandom_range(16'hE000, 16'hFFFF));
   endfunction

   function automatic logic [15:0] gain16();
      return 16'($urandom_range(0, 16'h0FFF));
   endfunction

   // Rewrite every register once the pipeline has emptied
   task automatic load_coeffs(coeff_set_type kind, logic mode);
      logic [63:0] igbt_d;
      logic [63:0] igbt_g;
      logic [63:0] diode_d;
      logic [63:0] diode_g;
      logic [63:0] chan;
      logic [31:0] pad;
      logic [3:0]  shift;
      wait_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      case (kind)
         COEFF_ZERO: begin
            {igbt_d, igbt_g, diode_d, diode_g, chan, pad} = '0;
            shift = 4'd0;
         end
         COEFF_FULL: begin
            {igbt_d, igbt_g, diode_d, diode_g, chan, pad} = '1;
            shift = 4'hF;
         end
         COEFF_RANDOM: begin
            igbt_d  = {$urandom, $urandom};
            igbt_g  = {$urandom, $urandom};
            diode_d = {$urandom, $urandom};
            diode_g = {$urandom, $urandom};
            chan    = {$urandom, $urandom};
            pad     = $urandom;
            shift   = 4'($urandom);
         end
         default: begin
            igbt_d  = {decay16(), decay16(), decay16(), decay16()};
            igbt_g  = {gain16(), gain16(), gain16(), gain16()};
            diode_d = {decay16(), decay16(), decay16(), decay16()};
            diode_g = {gain16(), gain16(), gain16(), gain16()};
            chan    = {gain16(), decay16(), gain16(), decay16()};
            pad     = {gain16(), decay16()};
            shift   = 4'($urandom_range(0, 4));
         end
      endcase
      csr_write(REG_IGBT_DECAY, igbt_d);
      csr_write(REG_IGBT_GAIN, igbt_g);
      csr_write(REG_DIODE_DECAY, diode_d);
      csr_write(REG_DIODE_GAIN, diode_g);
      csr_write(REG_CHANNEL_COEFF, chan);
      // Narrow registers get junk in the unused upper bits
      csr_write(REG_PAD_COEFF, {$urandom, pad});
      csr_write(REG_GAIN_SHIFT, {$urandom, 28'($urandom), shift});
      csr_write(REG_SOLVER_MODE, {$urandom, 31'($urandom), mode});
   endtask

   task automatic send_sample(logic [31:0] p_igbt, logic [31:0] p_diode, logic [31:0] ambient);
      int gap;
      if (!steady && $urandom_range(0, 99) < 17) begin
         gap = $urandom_range(1, 2);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {ambient, p_diode, p_igbt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] edge_value();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0:       v = Q_MAX;
         1:       v = Q_MIN;
         2:       v = '0;
         default: v = '1;
      endcase
      return v;
   endfunction

   // Mostly watts in a plausible band, some full-range and edge values
   function automatic logic [31:0] pick_loss();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = edge_value();
         1, 2, 3: v = $urandom;
         default: v = 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_ambient();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = edge_value();
         1, 2:    v = $urandom;
         default: v = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      endcase
      return v;
   endfunction

   initial begin
      coeff_set_type kind;
      logic          mode;
      board       = new();
      steady      = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero coefficients: results follow ambient alone
      send_sample('0, '0, '0);
      send_sample(Q_MAX, Q_MAX, Q_MAX);
      send_sample(Q_MIN, Q_MIN, Q_MIN);

      // Full-scale coefficients: drive rises, pad sum and junction sums to saturation
      load_coeffs(COEFF_FULL, MODE_EULER);
      send_sample(Q_MAX, Q_MAX, '0);
      send_sample(Q_MAX, Q_MAX, Q_MAX);
      send_sample(Q_MIN, Q_MIN, '0);
      send_sample(Q_MIN, Q_MIN, Q_MIN);
      send_sample(Q_MAX, Q_MIN, Q_MAX);
      send_sample('1, 32'd1, Q_MIN);

      // Steady heating at 10 W and 3 W, 25 degrees ambient
      load_coeffs(COEFF_TYPICAL, MODE_EULER);
      repeat (6) send_sample(32'h000A_0000, 32'h0003_0000, 32'h0019_0000);

      // Hold mode: state frozen, ambient still passes through
      load_coeffs(COEFF_TYPICAL, MODE_HOLD);
      send_sample(Q_MAX, Q_MIN, 32'hFFD8_0000);
      send_sample(pick_loss(), pick_loss(), Q_MAX);
      send_sample(pick_loss(), pick_loss(), Q_MIN);

      // Random phases, one coefficient set each
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            1:       kind = COEFF_RANDOM;
            3:       kind = COEFF_FULL;
            5:       kind = COEFF_ZERO;
            default: kind = COEFF_TYPICAL;
         endcase
         mode = (p == 4 || $urandom_range(0, 5) == 0) ? MODE_HOLD : MODE_EULER;
         load_coeffs(kind, mode);
         steady = (p == 2);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (p == 1 && i == PHASE_WORDS / 2) wait_results();
            send_sample(pick_loss(), pick_loss(), pick_ambient());
         end
         steady = 1'b0;
      end

      wait_results();
      repeat (2 * DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
